### design/mtf_pkg.sv
`default_nettype none

package mtf_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Largest signed value; seeds the minimum before a rescan.
    localparam logic [DATA_W-1:0] MIN_INIT = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic deq_take;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic out_busy;
        logic hit_min;
        logic scan_last;
    } t_dp_sts;

    // Ring index advance with wrap at DEPTH.
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = IDX_W'(i + 1'b1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/mtf_ram.sv
`default_nettype none

module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### design/mtf_ctrl.sv
`default_nettype none

module mtf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_mode,
    input  wire mtf_pkg::t_dp_sts i_sts,
    output mtf_pkg::t_dp_cmd      o_cmd
);
    import mtf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_sts.out_busy;
                if (i_in_valid && !i_sts.out_busy) begin
                    o_cmd.start = 1'b1;
                    // Only a dequeue that finds data needs the stored entry.
                    if (i_mode == MODE_DEQ && !i_sts.empty) begin
                        n_state = ST_DEQ;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DEQ: begin
                o_cmd.deq_take = 1'b1;
                if (i_sts.hit_min) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.load_out = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/mtf_dp.sv
`default_nettype none

module mtf_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mtf_pkg::t_dp_cmd                   i_cmd,
    output mtf_pkg::t_dp_sts                        o_sts,
    input  wire logic                               i_mode,
    input  wire logic signed [mtf_pkg::DATA_W-1:0]  i_value,
    output logic                                    o_wr_en,
    output logic             [mtf_pkg::IDX_W-1:0]   o_wr_addr,
    output logic             [mtf_pkg::DATA_W-1:0]  o_wr_data,
    output logic             [mtf_pkg::IDX_W-1:0]   o_rd_addr,
    input  wire logic        [mtf_pkg::DATA_W-1:0]  i_rd_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [mtf_pkg::DATA_W-1:0]  o_removed_value,
    output logic                                    o_removed_valid,
    output logic signed      [mtf_pkg::DATA_W-1:0]  o_min_value,
    output logic                                    o_min_valid,
    output logic             [mtf_pkg::CNT_W-1:0]   o_count,
    output logic                                    o_rejected
);
    import mtf_pkg::*;

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_scan_ptr;
    logic [CNT_W-1:0]  r_scan_left;
    logic [DATA_W-1:0] r_min;
    logic [DATA_W-1:0] r_removed;
    logic              r_removed_valid;
    logic              r_rejected;
    logic              r_out_valid;
    logic              w_empty;
    logic              w_full;
    logic              w_enq;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_enq   = (i_mode == MODE_ENQ);

    assign o_sts.empty     = w_empty;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_sts.hit_min   = (i_rd_data == r_min) && (r_count > CNT_W'(1));
    assign o_sts.scan_last = (r_scan_left == CNT_W'(1));

    assign o_wr_en   = i_cmd.start && w_enq && !w_full;
    assign o_wr_addr = r_tail;
    assign o_wr_data = i_value;

    // The front entry is fetched on accept, the entry after it while the
    // dequeue completes, and the rest from the scan pointer.
    always_comb begin
        if (i_cmd.deq_take) begin
            o_rd_addr = next_slot(r_head);
        end else if (i_cmd.scan_step) begin
            o_rd_addr = r_scan_ptr;
        end else begin
            o_rd_addr = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_scan_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start && w_enq && !w_full) begin
                r_tail  <= next_slot(r_tail);
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.deq_take) begin
                r_head  <= next_slot(r_head);
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_left <= r_count - 1'b1;
            end else if (i_cmd.scan_step) begin
                r_scan_left <= r_scan_left - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_removed       <= '0;
            r_removed_valid <= 1'b0;
            r_rejected      <= w_enq ? w_full : w_empty;
            if (w_enq && !w_full &&
                (w_empty || $signed(i_value) < $signed(r_min))) begin
                r_min <= i_value;
            end
        end
        if (i_cmd.deq_take) begin
            r_removed       <= i_rd_data;
            r_removed_valid <= 1'b1;
        end
        if (i_cmd.scan_start) begin
            r_min      <= MIN_INIT;
            r_scan_ptr <= next_slot(next_slot(r_head));
        end
        if (i_cmd.scan_step) begin
            r_scan_ptr <= next_slot(r_scan_ptr);
            if ($signed(i_rd_data) < $signed(r_min)) begin
                r_min <= i_rd_data;
            end
        end
        if (i_cmd.load_out) begin
            o_removed_value <= r_removed;
            o_removed_valid <= r_removed_valid;
            o_min_value     <= w_empty ? '0 : r_min;
            o_min_valid     <= !w_empty;
            o_count         <= r_count;
            o_rejected      <= r_rejected;
        end
    end

    assign o_out_valid = r_out_valid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_empty_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_reject_no_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(o_rejected && o_removed_valid))
        else $error("rejected item reports a removed entry");

    a_min_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_min_valid == (o_count != '0)))
        else $error("minimum flag disagrees with count");

endmodule

`default_nettype wire

### design/min_tracking_fifo.sv
// Bounded FIFO of signed 32-bit values that also reports the smallest
// value it holds.
//
// Input channel (i_in_valid / o_in_ready): each item carries i_mode and
// i_value. Mode enqueue writes the value at the rear; mode dequeue removes
// the oldest entry and ignores the value. An enqueue on a full queue or a
// dequeue on an empty one leaves the state alone and is flagged rejected.
//
// Output channel (o_out_valid / i_out_ready): exactly one result item per
// input item, giving the removed value, the minimum after the operation
// with its valid flag, the count and the rejected flag.
//
// Sequence: an enqueue or a refused item goes from accept straight to the
// result load, a dequeue passes a dequeue completion step first, and a
// dequeue that removes the current minimum also rescans the N entries left.
// The rescan reads the one storage read port once per cycle. One item is in
// work at a time.
//
// Reset empties the queue and drops any pending result. While the receiver
// stalls, the result is held and a new item is only taken once it leaves.
`default_nettype none

module min_tracking_fifo (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_mode,
    input  wire logic signed [mtf_pkg::DATA_W-1:0]  i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [mtf_pkg::DATA_W-1:0]  o_removed_value,
    output logic                                    o_removed_valid,
    output logic signed      [mtf_pkg::DATA_W-1:0]  o_min_value,
    output logic                                    o_min_valid,
    output logic             [mtf_pkg::CNT_W-1:0]   o_count,
    output logic                                    o_rejected
);
    import mtf_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;

    // Sequencer: accept, dequeue completion, rescan, result load.
    mtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Ring pointers, count, running minimum and the result register.
    mtf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_wr_en         (w_wr_en),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data),
        .o_rd_addr       (w_rd_addr),
        .i_rd_data       (w_rd_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_removed_value (o_removed_value),
        .o_removed_valid (o_removed_valid),
        .o_min_value     (o_min_value),
        .o_min_valid     (o_min_valid),
        .o_count         (o_count),
        .o_rejected      (o_rejected)
    );

    // Entry storage; only data read from slots between head and tail is ever used.
    mtf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

`default_nettype wire
